[hdl/utf7d_pkg.sv]
`timescale 1ns / 1ps

package utf7d_pkg;

    // Decoder modes.
    typedef enum logic [1:0] {
        MODE_DIRECT = 2'd0,
        MODE_PLUS   = 2'd1,
        MODE_B64    = 2'd2
    } mode_t;

    // Result kinds.
    localparam logic [1:0] KIND_CHAR    = 2'd0;
    localparam logic [1:0] KIND_CTRL    = 2'd1;
    localparam logic [1:0] KIND_UNKNOWN = 2'd2;

    // Bytes with a special meaning in the stream.
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HIGH  = 8'h80;

    localparam logic [15:0] UNIT_BOM    = 16'hFEFF;
    localparam logic [5:0]  SURR_HIGH   = 6'b110110;
    localparam logic [5:0]  SURR_LOW    = 6'b110111;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;
    localparam logic [4:0]  UNIT_BITS   = 5'd16;
    localparam logic [6:0]  DIGIT_BITS  = 7'd6;

    // Decoder state carried from one byte to the next.
    typedef struct packed {
        mode_t       mode;
        logic [4:0]  bit_pos;
        logic [15:0] partial;
        logic [15:0] pending;
    } utf7d_state_t;

    localparam utf7d_state_t STATE_RESET = '{
        mode:    MODE_DIRECT,
        bit_pos: UNIT_BITS,
        partial: 16'h0000,
        pending: 16'h0000
    };

    // One decoded result, if any.
    typedef struct packed {
        logic        emit;
        logic [20:0] code_point;
        logic [1:0]  kind;
    } utf7d_result_t;

    // Base64 digit lookup: bit 6 is set when the byte is a digit.
    function automatic logic [6:0] b64_digit(input logic [7:0] ch);
        logic [7:0] val;
        logic       ok;
        val = 8'h00;
        ok  = 1'b1;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            val = ch - 8'h41;
        end
        else if (ch >= 8'h61 && ch <= 8'h7A) begin
            val = ch - 8'h61 + 8'd26;
        end
        else if (ch >= 8'h30 && ch <= 8'h39) begin
            val = ch - 8'h30 + 8'd52;
        end
        else if (ch == CH_PLUS) begin
            val = 8'd62;
        end
        else if (ch == CH_SLASH) begin
            val = 8'd63;
        end
        else begin
            ok = 1'b0;
        end
        return {ok, val[5:0]};
    endfunction

    // Classification of a byte that is passed through as direct text.
    function automatic logic [1:0] direct_kind(input logic [7:0] ch);
        logic [1:0] k;
        if (ch >= CH_HIGH) begin
            k = KIND_UNKNOWN;
        end
        else if (ch < CH_SPACE || ch == CH_DEL) begin
            k = KIND_CTRL;
        end
        else begin
            k = KIND_CHAR;
        end
        return k;
    endfunction

endpackage

[hdl/utf7d_step.sv]
`timescale 1ns / 1ps

module utf7d_step (
    input  utf7d_pkg::utf7d_state_t  cur_state,
    input  logic                     restart,
    input  logic [7:0]               in_byte,
    output utf7d_pkg::utf7d_state_t  next_state,
    output utf7d_pkg::utf7d_result_t result
);
    import utf7d_pkg::*;

    utf7d_state_t       st;
    utf7d_state_t       nx;
    utf7d_result_t      res;
    logic [6:0]         digit;
    logic [5:0]         b;
    logic signed [6:0]  shift;
    logic [6:0]         neg_shift;
    logic [6:0]         new_shift;
    logic [15:0]        unit;
    logic [31:0]        shifted;
    logic [20:0]        joined;

    // Bit placement of the incoming base64 digit.
    always_comb
    begin
        st        = restart ? STATE_RESET : cur_state;
        digit     = b64_digit(in_byte);
        b         = digit[5:0];
        shift     = $signed({2'b00, st.bit_pos}) - $signed(DIGIT_BITS);
        neg_shift = 7'd0 - shift;
        new_shift = shift + 7'd16;
        unit      = st.partial | ({10'd0, b} >> neg_shift[2:0]);
        if (shift <= 0) begin
            shifted = {26'd0, b} << new_shift[4:0];
        end
        else begin
            shifted = {26'd0, b} << shift[4:0];
        end
        joined = SUPP_BASE + {1'b0, st.pending[9:0], unit[9:0]};
    end

    // Mode handling, unit completion and surrogate pairing.
    always_comb
    begin
        nx  = st;
        res = '{emit: 1'b0, code_point: 21'd0, kind: KIND_CHAR};
        unique case (st.mode)
            MODE_PLUS, MODE_B64:
            begin
                if (st.mode == MODE_PLUS && in_byte == CH_MINUS) begin
                    nx.mode = MODE_DIRECT;
                    res     = '{emit: 1'b1, code_point: {13'd0, CH_PLUS}, kind: KIND_CHAR};
                end
                else if (digit[6]) begin
                    nx.mode = MODE_B64;
                    if (shift <= 0) begin
                        nx.bit_pos = new_shift[4:0];
                        nx.partial = shifted[15:0];
                        if (unit[15:10] == SURR_HIGH) begin
                            nx.pending = (st.pending == 16'h0000) ? unit : 16'h0000;
                        end
                        else if (unit[15:10] == SURR_LOW) begin
                            nx.pending = 16'h0000;
                            if (st.pending != 16'h0000) begin
                                res = '{emit: 1'b1, code_point: joined, kind: KIND_CHAR};
                            end
                        end
                        else if (unit != UNIT_BOM) begin
                            res = '{emit: 1'b1, code_point: {5'd0, unit}, kind: KIND_CHAR};
                        end
                    end
                    else begin
                        nx.bit_pos = shift[4:0];
                        nx.partial = st.partial | shifted[15:0];
                    end
                end
                else begin
                    // Any other byte closes the shift; a dash is consumed.
                    nx.mode = MODE_DIRECT;
                    if (in_byte != CH_MINUS) begin
                        res = '{emit: 1'b1, code_point: {13'd0, in_byte},
                                kind: direct_kind(in_byte)};
                    end
                end
            end
            default:
            begin
                if (in_byte == CH_PLUS) begin
                    nx = STATE_RESET;
                    nx.mode = MODE_PLUS;
                end
                else begin
                    nx.mode = MODE_DIRECT;
                    res = '{emit: 1'b1, code_point: {13'd0, in_byte},
                            kind: direct_kind(in_byte)};
                end
            end
        endcase
        next_state = nx;
        result     = res;
    end

endmodule

[hdl/utf7_stream_decoder_top.sv]
`timescale 1ns / 1ps

// UTF-7 stream decoder. One byte is taken per clock cycle while not stalled,
// and every byte is decoded in the cycle it is accepted: the base64 lookup,
// digit placement and surrogate pairing sit between the byte handshake and a
// single result register, so a character appears in the cycle after the byte
// that completes it. Bytes that produce no character ('+' opening a shift, '-'
// closing one, partial base64 digits, surrogate halves, byte order marks) are
// absorbed without a result. The byte side is stalled only while the result
// register holds a character that the receiving side is stalling.
module utf7_stream_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  in_byte,
    input  logic        restart,
    output logic        char_valid,
    input  logic        char_stall,
    output logic [20:0] code_point,
    output logic [1:0]  kind
);
    import utf7d_pkg::*;

    utf7d_state_t  state_reg;
    utf7d_state_t  state_next;
    utf7d_result_t result;
    logic          char_valid_reg;
    logic          char_valid_next;
    logic [20:0]   code_point_reg;
    logic [1:0]    kind_reg;
    logic          accept;

    utf7d_step u_step (
        .cur_state  (state_reg),
        .restart    (restart),
        .in_byte    (in_byte),
        .next_state (state_next),
        .result     (result)
    );

    // A request is taken when the result register is free or is being drained.
    assign byte_stall = char_valid_reg & char_stall;
    assign accept     = byte_valid & ~byte_stall;

    always_comb
    begin
        char_valid_next = char_valid_reg;
        if (char_valid_reg && !char_stall) begin
            char_valid_next = 1'b0;
        end
        if (accept && result.emit) begin
            char_valid_next = 1'b1;
        end
    end

    // Decoder state and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= STATE_RESET;
            char_valid_reg <= 1'b0;
        end
        else begin
            if (accept) begin
                state_reg <= state_next;
            end
            char_valid_reg <= char_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (accept && result.emit) begin
            code_point_reg <= result.code_point;
            kind_reg       <= result.kind;
        end
    end

    assign char_valid = char_valid_reg;
    assign code_point = code_point_reg;
    assign kind       = kind_reg;

endmodule
